// File: rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared widths and the result record of the UTF-8 to 16-bit unit decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int PEND_W  = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [UNIT_W-1:0] unit_t;
  typedef logic [PEND_W-1:0] pend_t;

  typedef struct packed {
    unit_t code_unit;
    unit_t unit_count;
    logic  is_end;
  } u8u16_res_t;

endpackage

// File: rtl/u8u16_in_if.sv
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte channel into the decoder: valid/ready with one byte and a last flag.
// ----------------------------------------------------------------------------
interface u8u16_in_if
  import u8u16_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/u8u16_out_if.sv
// ----------------------------------------------------------------------------
// u8u16_out_if
// Result channel out of the decoder: valid/ready with one code unit record.
// ----------------------------------------------------------------------------
interface u8u16_out_if
  import u8u16_pkg::*;
();
  logic  valid;
  logic  ready;
  unit_t code_unit;
  unit_t unit_count;
  logic  is_end;

  modport source (output valid, output code_unit, output unit_count, output is_end,
                  input ready);
  modport sink   (input valid, input code_unit, input unit_count, input is_end,
                  output ready);
endinterface

// File: rtl/utf8_to_utf16_unit_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_unit_decoder
// Decodes a UTF-8 byte stream into 16-bit code units plus an end record.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte per transaction; in_last marks the final byte of a
//   string. out_ch carries one record per transaction: a code unit with the
//   running unit count, or, after the final byte, an end record (is_end = 1,
//   code_unit = 0, unit_count = total units of the string).
//   cfg_we/cfg_wdata write out_capacity; write it only while the block is idle.
//   Once out_capacity units are out, bytes that would start a new character
//   are dropped until the end of the string.
// Queueing and throughput:
//   A record is written to the result queue when its byte is taken. One byte
//   is taken per cycle while in_ch.ready is high; a final byte that also
//   completes a character yields two records. Records wait in a four-entry result
//   queue, and in_ch.ready stays high while at least two entries are free, so
//   input keeps flowing while a finished record waits for out_ch.ready.
// Reset:
//   rst_n clears the decode state, the queue and sets out_capacity to 65535.
//   When the receiver stalls, the queue fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
module utf8_to_utf16_unit_decoder
  import u8u16_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  u8u16_in_if.sink           in_ch,
  u8u16_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [UNIT_W-1:0]  cfg_wdata
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // decode state
  pend_t pend_r, pend_nxt;
  unit_t acc_r, acc_nxt;
  unit_t units_r, units_nxt;
  unit_t cap_r;

  // result queue
  u8u16_res_t           res_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]    cnt_r, cnt_nxt;

  logic        in_fire, out_fire;
  pend_t       lead_len;
  byte_t       lead_mask;
  logic        emit;
  unit_t       unit_val;
  unit_t       units_emit;
  logic [QPTR_W-1:0] term_idx;
  logic [1:0]  push_cnt;

  assign in_ch.ready = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (cnt_r != '0);
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign out_ch.code_unit  = res_r[rd_ptr_r].code_unit;
  assign out_ch.unit_count = res_r[rd_ptr_r].unit_count;
  assign out_ch.is_end     = res_r[rd_ptr_r].is_end;

  // lead byte: sequence length and payload mask
  always_comb begin
    unique casez (in_ch.in_byte)
      8'b110?_????: begin lead_len = 3'd2; lead_mask = 8'h1F; end
      8'b1110_????: begin lead_len = 3'd3; lead_mask = 8'h0F; end
      8'b1111_0???: begin lead_len = 3'd4; lead_mask = 8'h07; end
      8'b1111_10??: begin lead_len = 3'd5; lead_mask = 8'h03; end
      default:      begin lead_len = 3'd1; lead_mask = 8'hFF; end
    endcase
  end

  always_comb begin
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    emit      = 1'b0;
    unit_val  = '0;
    if (pend_r != '0) begin
      // continuation: top bits are not checked
      acc_nxt  = {acc_r[UNIT_W-7:0], in_ch.in_byte[5:0]};
      pend_nxt = pend_r - 3'd1;
      if (pend_nxt == '0) begin
        emit     = 1'b1;
        unit_val = acc_nxt;
      end
    end else if (units_r < cap_r) begin
      if (lead_len > 3'd1) begin
        acc_nxt  = {8'h00, in_ch.in_byte & lead_mask};
        pend_nxt = lead_len - 3'd1;
      end else begin
        emit     = 1'b1;
        unit_val = {8'h00, in_ch.in_byte};
      end
    end
    // flush a sequence cut short by the end of the string
    if (in_ch.in_last && pend_nxt != '0) begin
      emit     = 1'b1;
      unit_val = acc_nxt;
    end
    units_emit = units_r + {{(UNIT_W-1){1'b0}}, emit};
    units_nxt  = units_emit;
    if (in_ch.in_last) begin
      pend_nxt  = '0;
      acc_nxt   = '0;
      units_nxt = '0;
    end
  end

  assign term_idx = wr_ptr_r + {{(QPTR_W-1){1'b0}}, emit};
  assign push_cnt = in_fire ? ({1'b0, emit} + {1'b0, in_ch.in_last}) : 2'd0;
  assign cnt_nxt  = cnt_r + QCNT_W'(push_cnt) - QCNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      acc_r    <= '0;
      units_r  <= '0;
      cap_r    <= '1;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_fire) begin
        pend_r   <= pend_nxt;
        acc_r    <= acc_nxt;
        units_r  <= units_nxt;
        wr_ptr_r <= wr_ptr_r + QPTR_W'(push_cnt);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // queue entries carry no reset
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res_r[wr_ptr_r] <= '{code_unit: unit_val, unit_count: units_emit, is_end: 1'b0};
    end
    if (in_fire && in_ch.in_last) begin
      res_r[term_idx] <= '{code_unit: '0, unit_count: units_emit, is_end: 1'b1};
    end
  end

endmodule

// File: rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level assertions for the decoder, attached to the decoder by bind.
// ----------------------------------------------------------------------------
module u8u16_checker
  import u8u16_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input unit_t code_unit,
  input unit_t unit_count,
  input logic  is_end
);

  // no stale records after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result channel valid right after reset");

  // input side open after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // a code unit always counts itself
  a_unit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_end |-> unit_count != '0)
    else $error("code unit record with zero count");

  // end record carries a zero unit
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_end |-> code_unit == '0)
    else $error("end record with nonzero code unit");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_unit)
      && $stable(unit_count) && $stable(is_end))
    else $error("stalled result changed");

endmodule

bind utf8_to_utf16_unit_decoder u8u16_checker u_u8u16_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .code_unit  (out_ch.code_unit),
  .unit_count (out_ch.unit_count),
  .is_end     (out_ch.is_end)
);
